/* hdl/sidtoa_pkg.sv */
`default_nettype none

package sidtoa_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = DIGIT_W * NUM_DIGITS;
  localparam int SHIFT_CNT_W = $clog2(VALUE_W);
  localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

  // one classified request: sign and magnitude
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } sidtoa_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIND,
    ST_SIGN,
    ST_DIGITS
  } sidtoa_state_t;

endpackage

`default_nettype wire

/* hdl/signed_int_to_decimal_ascii.sv */
// An accepted request passes the front register, the queue, 32 shift steps of the
// double-dabble converter, one digit search and the output register before its
// first character appears, then one character per cycle while unstalled.
// The serial converter handles one request at a time; while it works, and during
// output stalls, the front stage and queue take new requests.
// Reset (synchronous, active high) empties the front stage, queue and output.
`default_nettype none

module signed_int_to_decimal_ascii #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               value_valid,
  output logic                    value_stall,
  input  wire logic signed [31:0] value,
  output logic                    text_valid,
  input  wire logic               text_stall,
  output logic [7:0]              text_char,
  output logic                    last
);
  import sidtoa_pkg::*;

  logic         push;
  sidtoa_item_t push_item;
  logic         queue_full;
  logic         pop;
  sidtoa_item_t pop_item;
  logic         queue_empty;

  sidtoa_front u_front (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value),
    .push        (push),
    .push_item   (push_item),
    .queue_full  (queue_full)
  );

  sidtoa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (queue_empty)
  );

  sidtoa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (queue_empty),
    .pop_item   (pop_item),
    .pop        (pop),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_char  (text_char),
    .last       (last)
  );

endmodule

`default_nettype wire

/* hdl/sidtoa_front.sv */
`default_nettype none

module sidtoa_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          value_valid,
  output logic                               value_stall,
  input  wire logic signed [31:0]            value,
  output logic                               push,
  output sidtoa_pkg::sidtoa_item_t           push_item,
  input  wire logic                          queue_full
);
  import sidtoa_pkg::*;

  logic         f_valid;
  logic         f_valid_next;
  sidtoa_item_t f_item;
  logic         accept;
  logic [VALUE_W-1:0] raw;

  assign raw         = $unsigned(value);
  assign value_stall = f_valid && queue_full;
  assign accept      = value_valid && !value_stall;
  assign push        = f_valid && !queue_full;
  assign push_item   = f_item;

  always_comb begin
    f_valid_next = f_valid;
    if (push) f_valid_next = 1'b0;
    if (accept) f_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  // magnitude in unsigned arithmetic, so the most negative value needs no care
  always_ff @(posedge clk) begin
    if (accept) begin
      f_item.neg <= raw[VALUE_W-1];
      f_item.mag <= raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
    end
  end

endmodule

`default_nettype wire

/* hdl/sidtoa_queue.sv */
`default_nettype none

module sidtoa_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  sidtoa_pkg::sidtoa_item_t push_item,
  output logic                     full,
  input  wire logic                pop,
  output sidtoa_pkg::sidtoa_item_t pop_item,
  output logic                     empty
);
  import sidtoa_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sidtoa_item_t     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop)      count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_item;
  end

endmodule

`default_nettype wire

/* hdl/sidtoa_back.sv */
`default_nettype none

module sidtoa_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                empty,
  input  sidtoa_pkg::sidtoa_item_t pop_item,
  output logic                     pop,
  output logic                     text_valid,
  input  wire logic                text_stall,
  output logic [7:0]               text_char,
  output logic                     last
);
  import sidtoa_pkg::*;

  sidtoa_state_t          state, state_next;
  logic [VALUE_W-1:0]     sh, sh_next;
  logic [BCD_W-1:0]       bcd, bcd_next;
  logic [BCD_W-1:0]       bcd_adj;
  logic [SHIFT_CNT_W-1:0] cnt, cnt_next;
  logic                   neg, neg_next;
  logic [DIGIT_IDX_W-1:0] idx, idx_next;
  logic [DIGIT_IDX_W-1:0] top_idx;
  logic [DIGIT_W-1:0]     digs [NUM_DIGITS];
  logic                   text_valid_next;
  logic [CHAR_W-1:0]      text_char_next;
  logic                   last_next;
  logic                   out_free;

  // add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      digs[i] = bcd[i*DIGIT_W +: DIGIT_W];
      bcd_adj[i*DIGIT_W +: DIGIT_W] = (digs[i] >= DIGIT_W'(5)) ?
                                      digs[i] + DIGIT_W'(3) : digs[i];
    end
  end

  // highest nonzero digit, zero when all digits are zero
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digs[i] != '0) top_idx = DIGIT_IDX_W'(i);
    end
  end

  assign out_free = !text_valid || !text_stall;

  always_comb begin
    state_next      = state;
    sh_next         = sh;
    bcd_next        = bcd;
    cnt_next        = cnt;
    neg_next        = neg;
    idx_next        = idx;
    pop             = 1'b0;
    text_valid_next = text_valid && text_stall;
    text_char_next  = text_char;
    last_next       = last;
    unique case (state)
      ST_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          sh_next    = pop_item.mag;
          neg_next   = pop_item.neg;
          bcd_next   = '0;
          cnt_next   = '0;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_next = {bcd_adj[BCD_W-2:0], sh[VALUE_W-1]};
        sh_next  = {sh[VALUE_W-2:0], 1'b0};
        cnt_next = cnt + SHIFT_CNT_W'(1);
        if (cnt == SHIFT_CNT_W'(VALUE_W - 1)) state_next = ST_FIND;
      end
      ST_FIND: begin
        idx_next   = top_idx;
        state_next = neg ? ST_SIGN : ST_DIGITS;
      end
      ST_SIGN: begin
        if (out_free) begin
          text_valid_next = 1'b1;
          text_char_next  = CHAR_MINUS;
          last_next       = 1'b0;
          state_next      = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (out_free) begin
          text_valid_next = 1'b1;
          text_char_next  = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digs[idx]};
          last_next       = (idx == '0);
          if (idx == '0) state_next = ST_IDLE;
          else idx_next = idx - DIGIT_IDX_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      text_valid <= 1'b0;
    end else begin
      state      <= state_next;
      text_valid <= text_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    sh        <= sh_next;
    bcd       <= bcd_next;
    cnt       <= cnt_next;
    neg       <= neg_next;
    idx       <= idx_next;
    text_char <= text_char_next;
    last      <= last_next;
  end

endmodule

`default_nettype wire

/* bench/signed_int_to_decimal_ascii_test.sv */
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_test;
  import sidtoa_pkg::*;

  typedef struct {
    logic [VALUE_W-1:0] value;
    string              text;  // empty: derive the text from the predictor
  } directed_row_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      value_valid;
  logic                      value_stall;
  logic signed [VALUE_W-1:0] value;
  logic                      text_valid;
  logic                      text_stall = 1'b0;
  logic [CHAR_W-1:0]         text_char;
  logic                      last;

  logic [CHAR_W-1:0] expected_char[$];
  logic              expected_last[$];
  directed_row_t     directed_rows[$];

  int unsigned error_count = 0;
  int unsigned burst_left = 0;
  int unsigned stall_phase = 0;
  logic [CHAR_W-1:0] want_char;
  logic              want_last;

  signed_int_to_decimal_ascii u_dut (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_char   (text_char),
    .last        (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Queue the decimal text of one request: sign first, then digits, most significant first.
  function automatic void predict_text(input logic [VALUE_W-1:0] raw);
    logic [VALUE_W-1:0] mag;
    logic [CHAR_W-1:0]  digit_chars[NUM_DIGITS];
    int                 digit_count;
    mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
    digit_count = 0;
    do begin
      digit_chars[digit_count] = CHAR_ZERO + CHAR_W'(mag % 10);
      mag = mag / 10;
      digit_count++;
    end while (mag != 0 && digit_count < NUM_DIGITS);
    if (raw[VALUE_W-1]) begin
      expected_char.push_back(CHAR_MINUS);
      expected_last.push_back(1'b0);
    end
    for (int k = digit_count - 1; k >= 0; k--) begin
      expected_char.push_back(digit_chars[k]);
      expected_last.push_back(k == 0);
    end
  endfunction

  function automatic void queue_typed_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      expected_char.push_back(CHAR_W'(text[i]));
      expected_last.push_back(i == text.len() - 1);
    end
  endfunction

  function automatic void note_error();
    error_count++;
  endfunction

  // Hand one request over, with bursts and random gaps on the sending side.
  task automatic send_value(input logic [VALUE_W-1:0] v, input string text);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        value_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 8);
    end
    value_valid <= 1'b1;
    value       <= v;
    @(posedge clk);
    while (value_stall) @(posedge clk);
    if (text.len() != 0)
      queue_typed_text(text);
    else
      predict_text(v);
    burst_left--;
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    longint lo;
    longint hi;
    longint mag;
    longint pow10;
    int     digits;
    logic   neg;
    neg = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: begin
        digits = $urandom_range(1, NUM_DIGITS);
        lo = 1;
        for (int i = 1; i < digits; i++) lo = lo * 10;
        hi = lo * 10 - 1;
        if (digits == 1) lo = 0;
        if (hi > 64'sd2147483647) hi = neg ? 64'sd2147483648 : 64'sd2147483647;
        mag = lo + longint'({$urandom} % (hi - lo + 1));
      end
      7: begin
        pow10 = 1;
        digits = $urandom_range(0, NUM_DIGITS - 1);
        for (int i = 0; i < digits; i++) pow10 = pow10 * 10;
        mag = pow10 + $urandom_range(0, 2) - 1;
      end
      8: mag = $urandom_range(0, 20);
      default: mag = 64'sd2147483648 - $urandom_range(0, 3) - (neg ? 0 : 1);
    endcase
    return neg ? VALUE_W'(-mag) : VALUE_W'(mag);
  endfunction

  // Receiver stall: cycle through calm, light, heavy and periodic stretches.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    case (stall_phase[9:8])
      2'd0:    text_stall <= 1'b0;
      2'd1:    text_stall <= ($urandom_range(0, 3) == 0);
      2'd2:    text_stall <= ($urandom_range(0, 9) < 7);
      default: text_stall <= (stall_phase[2:0] < 3'd3);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && text_valid && !text_stall) begin
      if (expected_char.size() == 0) begin
        note_error();
        if (error_count <= 10)
          $display("unexpected character %0d last %0b", text_char, last);
      end else begin
        want_char = expected_char.pop_front();
        want_last = expected_last.pop_front();
        if (text_char !== want_char || last !== want_last) begin
          note_error();
          if (error_count <= 10)
            $display("mismatch: expected char %0d last %0b, got char %0d last %0b",
                     want_char, want_last, text_char, last);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    value_valid = 1'b0;
    value       = '0;

    directed_rows.push_back('{32'sd0, "0"});
    directed_rows.push_back('{32'sd2147483647, "2147483647"});
    directed_rows.push_back('{32'h8000_0000, "-2147483648"});
    directed_rows.push_back('{32'hFFFF_FFFF, "-1"});
    directed_rows.push_back('{32'sd1, "1"});
    directed_rows.push_back('{32'h8000_0001, "-2147483647"});
    directed_rows.push_back('{32'sd9, ""});
    directed_rows.push_back('{32'sd10, ""});
    directed_rows.push_back('{-32'sd10, ""});
    directed_rows.push_back('{32'sd99, ""});
    directed_rows.push_back('{32'sd100, ""});
    directed_rows.push_back('{-32'sd9, ""});
    directed_rows.push_back('{32'sd999999999, ""});
    directed_rows.push_back('{32'sd1000000000, ""});
    directed_rows.push_back('{-32'sd999999999, ""});
    directed_rows.push_back('{-32'sd1000000000, ""});
    directed_rows.push_back('{32'sd1234567890, ""});
    directed_rows.push_back('{-32'sd1234567890, ""});
    directed_rows.push_back('{32'h5555_5555, ""});
    directed_rows.push_back('{32'hAAAA_AAAA, ""});
    directed_rows.push_back('{32'sd2147483646, ""});
    directed_rows.push_back('{32'h8000_0002, ""});
    directed_rows.push_back('{32'sd0, "0"});

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_value(directed_rows[i].value, directed_rows[i].text);
    repeat (480)
      send_value(random_value(), "");
    value_valid <= 1'b0;

    while (expected_char.size() != 0) @(posedge clk);
    // drain: let any stray character show up before the verdict
    repeat (60) @(posedge clk);

    if (error_count == 0 && expected_char.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
hdl/sidtoa_pkg.sv
hdl/sidtoa_front.sv
hdl/sidtoa_queue.sv
hdl/sidtoa_back.sv
hdl/signed_int_to_decimal_ascii.sv
bench/signed_int_to_decimal_ascii_test.sv
